@@ rtl/core/mie_pkg.sv @@
// ----------------------------------------------------------------------------
// mie_pkg: shared types, codes and helpers of the I-type execute unit
// Opcode codes, load kinds, the stage record between execute and memory
// stage, and the byte-lane helpers used by both.
// ----------------------------------------------------------------------------
package mie_pkg;

  localparam logic [31:0] RESET_PC = 32'hBFC0_0000;

  localparam logic [5:0] OP_J      = 6'h02;
  localparam logic [5:0] OP_JAL    = 6'h03;
  localparam logic [5:0] OP_BEQ    = 6'h04;
  localparam logic [5:0] OP_BNE    = 6'h05;
  localparam logic [5:0] OP_BLEZ   = 6'h06;
  localparam logic [5:0] OP_BGTZ   = 6'h07;
  localparam logic [5:0] OP_ADDI   = 6'h08;
  localparam logic [5:0] OP_ADDIU  = 6'h09;
  localparam logic [5:0] OP_SLTI   = 6'h0A;
  localparam logic [5:0] OP_SLTIU  = 6'h0B;
  localparam logic [5:0] OP_ANDI   = 6'h0C;
  localparam logic [5:0] OP_ORI    = 6'h0D;
  localparam logic [5:0] OP_XORI   = 6'h0E;
  localparam logic [5:0] OP_LUI    = 6'h0F;
  localparam logic [5:0] OP_BEQL   = 6'h14;
  localparam logic [5:0] OP_BNEL   = 6'h15;
  localparam logic [5:0] OP_BLEZL  = 6'h16;
  localparam logic [5:0] OP_BGTZL  = 6'h17;
  localparam logic [5:0] OP_DADDI  = 6'h18;
  localparam logic [5:0] OP_DADDIU = 6'h19;
  localparam logic [5:0] OP_LDL    = 6'h1A;
  localparam logic [5:0] OP_LDR    = 6'h1B;
  localparam logic [5:0] OP_LQ     = 6'h1E;
  localparam logic [5:0] OP_SQ     = 6'h1F;
  localparam logic [5:0] OP_LB     = 6'h20;
  localparam logic [5:0] OP_LH     = 6'h21;
  localparam logic [5:0] OP_LWL    = 6'h22;
  localparam logic [5:0] OP_LW     = 6'h23;
  localparam logic [5:0] OP_LBU    = 6'h24;
  localparam logic [5:0] OP_LHU    = 6'h25;
  localparam logic [5:0] OP_LWR    = 6'h26;
  localparam logic [5:0] OP_LWU    = 6'h27;
  localparam logic [5:0] OP_SB     = 6'h28;
  localparam logic [5:0] OP_SH     = 6'h29;
  localparam logic [5:0] OP_SWL    = 6'h2A;
  localparam logic [5:0] OP_SW     = 6'h2B;
  localparam logic [5:0] OP_SDL    = 6'h2C;
  localparam logic [5:0] OP_SDR    = 6'h2D;
  localparam logic [5:0] OP_SWR    = 6'h2E;
  localparam logic [5:0] OP_CACHE  = 6'h2F;
  localparam logic [5:0] OP_PREF   = 6'h33;
  localparam logic [5:0] OP_LD     = 6'h37;
  localparam logic [5:0] OP_SD     = 6'h3F;

  localparam logic [1:0] BR_EQ  = 2'd0;
  localparam logic [1:0] BR_NE  = 2'd1;
  localparam logic [1:0] BR_LEZ = 2'd2;
  localparam logic [1:0] BR_GTZ = 2'd3;

  typedef enum logic [3:0] {
    LD_NONE, LD_B, LD_BU, LD_H, LD_HU, LD_W, LD_WU, LD_D, LD_Q,
    LD_DL, LD_DR, LD_WL, LD_WR
  } ld_kind_t;

  typedef struct packed {
    logic [31:0]  next_pc;
    logic         set_pending;
    logic         clr_pending;
    logic [31:0]  new_target;
    logic         reg_wr;
    logic         reg_hi;
    logic [4:0]   widx;
    logic [63:0]  alu_val;
    logic [63:0]  rt_val;
    ld_kind_t     ld_kind;
    logic [3:0]   ld_shift;
    logic [7:0]   ld_mask;
    logic         ld_sa_zero;
    logic         mem_rd;
    logic [31:0]  mem_addr;
    logic         st_en;
    logic [127:0] st_data;
    logic [15:0]  st_be;
    logic [31:0]  st_addr;
    logic         unh;
  } exec_t;

  function automatic logic [63:0] sx8(input logic [63:0] v);
    return {{56{v[7]}}, v[7:0]};
  endfunction

  function automatic logic [63:0] sx16(input logic [63:0] v);
    return {{48{v[15]}}, v[15:0]};
  endfunction

  function automatic logic [63:0] sx32(input logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  // Run of len ones starting at bit 0, len from 0 to 16.
  function automatic logic [15:0] len_mask(input logic [4:0] len);
    logic [16:0] t;
    t = (17'd1 << len) - 17'd1;
    return t[15:0];
  endfunction

  function automatic logic [63:0] merge_bytes(input logic [63:0] base,
                                              input logic [63:0] src,
                                              input logic [7:0]  mask);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = mask[i] ? src[8*i +: 8] : base[8*i +: 8];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/mie_channels.sv @@
// ----------------------------------------------------------------------------
// mie channels: valid/ready interfaces of the I-type execute unit
// Instruction channel, result channel and start-pc write channel.
// ----------------------------------------------------------------------------
interface mie_inst_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;
  modport source (output valid, output instruction, input ready);
  modport sink (input valid, input instruction, output ready);
endinterface

interface mie_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        dest_written;
  logic [4:0]  dest_index;
  logic [63:0] dest_value;
  logic        store_done;
  logic [31:0] store_address;
  logic        unhandled;
  modport source (output valid, output next_pc, output dest_written, output dest_index,
                  output dest_value, output store_done, output store_address,
                  output unhandled, input ready);
  modport sink (input valid, input next_pc, input dest_written, input dest_index,
                input dest_value, input store_done, input store_address,
                input unhandled, output ready);
endinterface

interface mie_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] start_pc;
  modport source (output valid, output start_pc, input ready);
  modport sink (input valid, input start_pc, output ready);
endinterface

@@ rtl/core/mie_regfile.sv @@
// ----------------------------------------------------------------------------
// mie_regfile: 32 x 128-bit general register file
// Two low-half read ports and one high-half read port with registered data.
// Valid bits give the zero reset value; a bypass covers a same-edge write.
// ----------------------------------------------------------------------------
module mie_regfile (
  input  logic        clk,
  input  logic        rst,
  input  logic        rd_en,
  input  logic [4:0]  rs_idx,
  input  logic [4:0]  rt_idx,
  output logic [63:0] rs_val,
  output logic [63:0] rt_val,
  output logic [63:0] rt_hi_val,
  input  logic        wr_en,
  input  logic        wr_hi,
  input  logic [4:0]  wr_idx,
  input  logic [63:0] wr_lo_data,
  input  logic [63:0] wr_hi_data
);
  logic [63:0] gpr_lo [32];
  logic [63:0] gpr_hi [32];
  logic [31:0] lo_ok;
  logic [31:0] hi_ok;
  logic [63:0] q_rs, q_rt, q_hi;
  logic        q_rs_ok, q_rt_ok, q_hi_ok;
  logic [4:0]  rs_r, rt_r;
  logic        byp_lo_vld, byp_hi_vld;
  logic [4:0]  byp_lo_idx, byp_hi_idx;
  logic [63:0] byp_lo, byp_hi;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      gpr_lo[wr_idx] <= wr_lo_data;
      if (wr_hi) begin
        gpr_hi[wr_idx] <= wr_hi_data;
      end
    end
    if (rd_en) begin
      q_rs <= gpr_lo[rs_idx];
      q_rt <= gpr_lo[rt_idx];
      q_hi <= gpr_hi[rt_idx];
      rs_r <= rs_idx;
      rt_r <= rt_idx;
    end
    if (wr_en) begin
      byp_lo_idx <= wr_idx;
      byp_lo     <= wr_lo_data;
      if (wr_hi) begin
        byp_hi_idx <= wr_idx;
        byp_hi     <= wr_hi_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lo_ok      <= '0;
      hi_ok      <= '0;
      q_rs_ok    <= 1'b0;
      q_rt_ok    <= 1'b0;
      q_hi_ok    <= 1'b0;
      byp_lo_vld <= 1'b0;
      byp_hi_vld <= 1'b0;
    end else begin
      if (rd_en) begin
        q_rs_ok <= lo_ok[rs_idx];
        q_rt_ok <= lo_ok[rt_idx];
        q_hi_ok <= hi_ok[rt_idx];
      end
      if (wr_en) begin
        lo_ok[wr_idx] <= 1'b1;
        byp_lo_vld    <= 1'b1;
        if (wr_hi) begin
          hi_ok[wr_idx] <= 1'b1;
          byp_hi_vld    <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (byp_lo_vld && (byp_lo_idx == rs_r)) begin
      rs_val = byp_lo;
    end else begin
      rs_val = q_rs_ok ? q_rs : '0;
    end
    if (byp_lo_vld && (byp_lo_idx == rt_r)) begin
      rt_val = byp_lo;
    end else begin
      rt_val = q_rt_ok ? q_rt : '0;
    end
    if (byp_hi_vld && (byp_hi_idx == rt_r)) begin
      rt_hi_val = byp_hi;
    end else begin
      rt_hi_val = q_hi_ok ? q_hi : '0;
    end
  end

endmodule

@@ rtl/core/mie_dmem.sv @@
// ----------------------------------------------------------------------------
// mie_dmem: byte-addressed data memory in two interleaved banks
// Even and odd 64-bit words live in separate banks, so any 16-byte window
// starting in word w (words w and w+1) is read or written in one access.
// ----------------------------------------------------------------------------
module mie_dmem #(
  parameter int MEM_WORDS = 4096
) (
  input  logic         clk,
  input  logic         rd_en,
  input  logic [31:0]  rd_addr,
  output logic [127:0] rd_data,
  input  logic         wr_en,
  input  logic [31:0]  wr_addr,
  input  logic [127:0] wr_data,
  input  logic [15:0]  wr_be
);
  import mie_pkg::*;

  localparam int WB    = $clog2(MEM_WORDS);
  localparam int HB    = WB - 1;
  localparam int DEPTH = MEM_WORDS / 2;

  logic [63:0]   bank0 [DEPTH];
  logic [63:0]   bank1 [DEPTH];
  logic [WB-1:0] rw, rw1, ww, ww1;
  logic [HB-1:0] r0_idx, r1_idx, w0_idx, w1_idx;
  logic [63:0]   q0, q1, w0_data, w1_data;
  logic [7:0]    w0_be, w1_be;
  logic          swap;

  assign rw     = rd_addr[WB+2:3];
  assign rw1    = rw + WB'(1);
  assign r0_idx = rw[0] ? rw1[WB-1:1] : rw[WB-1:1];
  assign r1_idx = rw[WB-1:1];

  assign ww      = wr_addr[WB+2:3];
  assign ww1     = ww + WB'(1);
  assign w0_idx  = ww[0] ? ww1[WB-1:1] : ww[WB-1:1];
  assign w1_idx  = ww[WB-1:1];
  assign w0_data = ww[0] ? wr_data[127:64] : wr_data[63:0];
  assign w1_data = ww[0] ? wr_data[63:0] : wr_data[127:64];
  assign w0_be   = ww[0] ? wr_be[15:8] : wr_be[7:0];
  assign w1_be   = ww[0] ? wr_be[7:0] : wr_be[15:8];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int i = 0; i < 8; i++) begin
        if (w0_be[i]) begin
          bank0[w0_idx][8*i +: 8] <= w0_data[8*i +: 8];
        end
        if (w1_be[i]) begin
          bank1[w1_idx][8*i +: 8] <= w1_data[8*i +: 8];
        end
      end
    end
    if (rd_en) begin
      q0   <= bank0[r0_idx];
      q1   <= bank1[r1_idx];
      swap <= rw[0];
    end
  end

  // Low half of the window is always the word that holds the address.
  assign rd_data = swap ? {q0, q1} : {q1, q0};

endmodule

@@ rtl/core/mie_exec.sv @@
// ----------------------------------------------------------------------------
// mie_exec: decode, ALU, branch and address stage
// Works on the instruction and its operands, and produces the record that
// the memory stage needs: register write, load shaping and store lanes.
// ----------------------------------------------------------------------------
module mie_exec (
  input  logic [31:0]    instruction,
  input  logic [31:0]    pc,
  input  logic           branch_pending,
  input  logic [31:0]    branch_target,
  input  logic [63:0]    rs_val,
  input  logic [63:0]    rt_val,
  input  logic [63:0]    rt_hi_val,
  output mie_pkg::exec_t ex
);
  import mie_pkg::*;

  logic [5:0]   op;
  logic [4:0]   rt;
  logic [15:0]  imm;
  logic [63:0]  simm;
  logic [31:0]  pc4, pc8, ea, ma, btgt, tgt;
  logic         quad;
  logic [2:0]   o;
  logic [1:0]   sa;
  logic         wr, br, cond, skip, mem_rd, st, unh;
  logic [4:0]   widx;
  logic [63:0]  val;
  ld_kind_t     ld;
  logic [2:0]   ld_back, st_back, ld_start, st_start;
  logic [4:0]   ld_len, st_len;
  logic [15:0]  ld_m16, st_m16;
  logic [3:0]   ld_shift, st_shift;
  logic [191:0] st_win;

  assign op   = instruction[31:26];
  assign rt   = instruction[20:16];
  assign imm  = instruction[15:0];
  assign simm = {{48{imm[15]}}, imm};
  assign pc4  = pc + 32'd4;
  assign pc8  = pc + 32'd8;
  assign ea   = rs_val[31:0] + simm[31:0];
  assign btgt = pc4 + {simm[29:0], 2'b00};
  assign quad = (op == OP_LQ) || (op == OP_SQ);
  assign ma   = quad ? {ea[31:4], 4'b0000} : ea;
  assign o    = ma[2:0];
  assign sa   = ma[1:0];

  always_comb begin
    wr       = 1'b0;
    widx     = rt;
    val      = '0;
    br       = 1'b0;
    cond     = 1'b0;
    skip     = 1'b0;
    tgt      = '0;
    ld       = LD_NONE;
    mem_rd   = 1'b0;
    st       = 1'b0;
    unh      = 1'b0;
    ld_back  = 3'd0;
    ld_start = 3'd0;
    ld_len   = 5'd0;
    st_back  = 3'd0;
    st_start = o;
    st_len   = 5'd0;
    unique case (op) inside
      OP_J, OP_JAL: begin
        br  = 1'b1;
        tgt = {pc4[31:28], instruction[25:0], 2'b00};
        if (op == OP_JAL) begin
          wr   = 1'b1;
          widx = 5'd31;
          val  = {32'd0, pc8};
        end
      end
      OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_BEQL, OP_BNEL, OP_BLEZL, OP_BGTZL: begin
        case (op[1:0])
          BR_EQ:   cond = (rs_val == rt_val);
          BR_NE:   cond = (rs_val != rt_val);
          BR_LEZ:  cond = (rs_val == '0) || rs_val[63];
          default: cond = (rs_val != '0) && !rs_val[63];
        endcase
        if (cond) begin
          br  = 1'b1;
          tgt = btgt;
        end else begin
          skip = op[4];
        end
      end
      OP_ADDI, OP_ADDIU: begin
        wr  = 1'b1;
        val = sx32({32'd0, ea});
      end
      OP_SLTI: begin
        wr  = 1'b1;
        val = {63'd0, $signed(rs_val) < $signed(simm)};
      end
      OP_SLTIU: begin
        wr  = 1'b1;
        val = {63'd0, rs_val < simm};
      end
      OP_ANDI: begin
        wr  = 1'b1;
        val = rs_val & {48'd0, imm};
      end
      OP_ORI: begin
        wr  = 1'b1;
        val = rs_val | {48'd0, imm};
      end
      OP_XORI: begin
        wr  = 1'b1;
        val = rs_val ^ {48'd0, imm};
      end
      OP_LUI: begin
        wr  = 1'b1;
        val = sx32({32'd0, imm, 16'd0});
      end
      OP_DADDI, OP_DADDIU: begin
        wr  = 1'b1;
        val = rs_val + simm;
      end
      OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW, OP_LWU, OP_LD, OP_LQ: begin
        wr     = 1'b1;
        mem_rd = 1'b1;
        unique case (op)
          OP_LB:   ld = LD_B;
          OP_LBU:  ld = LD_BU;
          OP_LH:   ld = LD_H;
          OP_LHU:  ld = LD_HU;
          OP_LW:   ld = LD_W;
          OP_LWU:  ld = LD_WU;
          OP_LD:   ld = LD_D;
          default: ld = LD_Q;
        endcase
      end
      OP_LDL: begin
        wr       = 1'b1;
        mem_rd   = 1'b1;
        ld       = LD_DL;
        ld_back  = 3'd7;
        ld_start = 3'd7 - o;
        ld_len   = 5'(o) + 5'd1;
      end
      OP_LDR: begin
        wr     = 1'b1;
        mem_rd = 1'b1;
        ld     = LD_DR;
        ld_len = 5'd8 - 5'(o);
      end
      OP_LWL: begin
        wr       = 1'b1;
        mem_rd   = 1'b1;
        ld       = LD_WL;
        ld_back  = 3'd3;
        ld_start = 3'd3 - {1'b0, sa};
        ld_len   = 5'(sa) + 5'd1;
      end
      OP_LWR: begin
        wr     = 1'b1;
        mem_rd = 1'b1;
        ld     = LD_WR;
        ld_len = 5'd4 - 5'(sa);
      end
      OP_SB: begin
        st     = 1'b1;
        st_len = 5'd1;
      end
      OP_SH: begin
        st     = 1'b1;
        st_len = 5'd2;
      end
      OP_SW: begin
        st     = 1'b1;
        st_len = 5'd4;
      end
      OP_SD: begin
        st     = 1'b1;
        st_len = 5'd8;
      end
      OP_SQ: begin
        st     = 1'b1;
        st_len = 5'd16;
      end
      OP_SWL: begin
        st       = 1'b1;
        st_back  = 3'd3;
        st_start = o - {1'b0, sa};
        st_len   = 5'(sa) + 5'd1;
      end
      OP_SWR: begin
        st     = 1'b1;
        st_len = 5'd4 - 5'(sa);
      end
      OP_SDL: begin
        st       = 1'b1;
        st_back  = 3'd7;
        st_start = 3'd0;
        st_len   = 5'(o) + 5'd1;
      end
      OP_SDR: begin
        st     = 1'b1;
        st_len = 5'd8 - 5'(o);
      end
      OP_CACHE, OP_PREF: begin
      end
      default: begin
        unh = 1'b1;
      end
    endcase
  end

  // Load window byte j of the result comes from window byte o + j - back.
  assign ld_shift = {1'b0, o} + 4'd8 - {1'b0, ld_back};
  // Store window byte p takes rt byte p - o + back.
  assign st_shift = 4'd8 - {1'b0, o} + {1'b0, st_back};
  assign ld_m16   = len_mask(ld_len) << ld_start;
  assign st_m16   = len_mask(st_len) << st_start;
  assign st_win   = {64'd0, rt_val, 64'd0} >> {st_shift, 3'b000};

  always_comb begin
    ex.next_pc     = branch_pending ? branch_target : (skip ? pc8 : pc4);
    ex.set_pending = !branch_pending && br;
    ex.clr_pending = branch_pending;
    ex.new_target  = tgt;
    ex.reg_wr      = wr && (widx != 5'd0);
    ex.reg_hi      = (ld == LD_Q);
    ex.widx        = widx;
    ex.alu_val     = val;
    ex.rt_val      = rt_val;
    ex.ld_kind     = ld;
    ex.ld_shift    = ld_shift;
    ex.ld_mask     = ld_m16[7:0];
    ex.ld_sa_zero  = (sa == 2'd0);
    ex.mem_rd      = mem_rd;
    ex.mem_addr    = ma;
    ex.st_en       = st;
    ex.st_data     = quad ? {rt_hi_val, rt_val} : st_win[127:0];
    ex.st_be       = st_m16;
    ex.st_addr     = ea;
    ex.unh         = unh;
  end

endmodule

@@ rtl/core/mips_itype_execute_unit.sv @@
// ----------------------------------------------------------------------------
// mips_itype_execute_unit: primary-opcode executor of a MIPS64-style core
// Register file and data memory are synchronous RAMs; each instruction is
// read, executed and written back through a short pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   inst    carries one 32-bit instruction word per item, taken to sit at
//           the current pc. result returns exactly one item per instruction:
//           the next pc, the register write, the store and the unhandled flag.
//   cfg     writes start_pc; the write loads the pc and drops any pending
//           delay-slot branch. Write it only while the unit is idle.
// Timing: an accepted instruction reads the register file in the cycle of
//   its acceptance, executes and addresses data memory in the next cycle,
//   and merges the memory data and writes back once the result register is
//   free; its result item is loaded into the result register at write-back.
//   A new instruction is not taken while one is in the execute stage: the register
//   read and the data memory read of one instruction follow each other, each from a synchronous RAM.
// Reset (rst, synchronous): the pc goes to 0xBFC00000, no branch is pending
//   and all registers read as zero. Data memory is not cleared.
// Stalls: the result register holds its item until result.ready; one more
//   instruction may be accepted and executed meanwhile, and it then waits in
//   the memory stage, with inst.ready low, until the result register frees.
// MEM_WORDS must be a power of two; byte addresses wrap at MEM_WORDS * 8.
// ----------------------------------------------------------------------------
module mips_itype_execute_unit #(
  parameter int MEM_WORDS = 4096
) (
  input  logic   clk,
  input  logic   rst,
  mie_inst_if.sink     inst,
  mie_cfg_if.sink      cfg,
  mie_result_if.source result
);
  import mie_pkg::*;

  logic         accept;
  logic         e_valid;
  logic         m_valid;
  logic         m_done;
  logic [31:0]  e_ins;
  logic [31:0]  pc;
  logic         br_pending;
  logic [31:0]  br_target;
  logic [63:0]  rs_val, rt_val, rt_hi_val;
  exec_t        ex;
  exec_t        m_op;
  logic [127:0] mem_q;
  logic [191:0] ld_window;
  logic [63:0]  ld_ext;
  logic [63:0]  ld_merged;
  logic [63:0]  wb_lo;
  logic [63:0]  wb_hi;

  // The memory stage completes when the result register is empty or is being
  // read. A new instruction enters only when the execute stage is free and
  // the memory stage is empty or completes in this cycle.
  assign m_done     = m_valid && (!result.valid || result.ready);
  assign inst.ready = !rst && !e_valid && (!m_valid || m_done);
  assign accept     = inst.valid && inst.ready;
  assign cfg.ready  = 1'b1;

  mie_regfile u_regfile (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (accept),
    .rs_idx     (inst.instruction[25:21]),
    .rt_idx     (inst.instruction[20:16]),
    .rs_val     (rs_val),
    .rt_val     (rt_val),
    .rt_hi_val  (rt_hi_val),
    .wr_en      (m_done && m_op.reg_wr),
    .wr_hi      (m_op.reg_hi),
    .wr_idx     (m_op.widx),
    .wr_lo_data (wb_lo),
    .wr_hi_data (wb_hi)
  );

  mie_exec u_exec (
    .instruction    (e_ins),
    .pc             (pc),
    .branch_pending (br_pending),
    .branch_target  (br_target),
    .rs_val         (rs_val),
    .rt_val         (rt_val),
    .rt_hi_val      (rt_hi_val),
    .ex             (ex)
  );

  mie_dmem #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dmem (
    .clk     (clk),
    .rd_en   (e_valid && ex.mem_rd),
    .rd_addr (ex.mem_addr),
    .rd_data (mem_q),
    .wr_en   (m_done && m_op.st_en),
    .wr_addr (m_op.mem_addr),
    .wr_data (m_op.st_data),
    .wr_be   (m_op.st_be)
  );

  // Pipeline control. The execute stage never stalls, since acceptance
  // already made sure the memory stage is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      e_valid <= accept;
      if (e_valid) begin
        m_valid <= 1'b1;
      end else if (m_done) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      e_ins <= inst.instruction;
    end
    if (e_valid) begin
      m_op <= ex;
    end
  end

  // The pc advances when an instruction leaves the execute stage, so the
  // next instruction already sees its own pc and the delay-slot state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= RESET_PC;
      br_pending <= 1'b0;
      br_target  <= '0;
    end else if (cfg.valid && cfg.ready) begin
      pc         <= cfg.start_pc;
      br_pending <= 1'b0;
    end else if (e_valid) begin
      pc <= ex.next_pc;
      if (ex.clr_pending) begin
        br_pending <= 1'b0;
      end else if (ex.set_pending) begin
        br_pending <= 1'b1;
        br_target  <= ex.new_target;
      end
    end
  end

  // Load shaping: bring the addressed bytes of the 16-byte window to the
  // bottom, then extend or merge them into the old register value.
  assign ld_window = {mem_q, 64'd0} >> {m_op.ld_shift, 3'b000};
  assign ld_ext    = ld_window[63:0];
  assign ld_merged = merge_bytes(m_op.rt_val, ld_ext, m_op.ld_mask);

  always_comb begin
    wb_hi = mem_q[127:64];
    case (m_op.ld_kind)
      LD_B:    wb_lo = sx8(ld_ext);
      LD_BU:   wb_lo = {56'd0, ld_ext[7:0]};
      LD_H:    wb_lo = sx16(ld_ext);
      LD_HU:   wb_lo = {48'd0, ld_ext[15:0]};
      LD_W:    wb_lo = sx32(ld_ext);
      LD_WU:   wb_lo = {32'd0, ld_ext[31:0]};
      LD_D:    wb_lo = ld_ext;
      LD_Q:    wb_lo = ld_ext;
      LD_DL:   wb_lo = ld_merged;
      LD_DR:   wb_lo = ld_merged;
      LD_WL:   wb_lo = sx32(ld_merged);
      // An aligned lwr behaves as lw; otherwise the upper word is kept.
      LD_WR:   wb_lo = m_op.ld_sa_zero ? sx32(ld_ext) : ld_merged;
      default: wb_lo = m_op.alu_val;
    endcase
  end

  // Result register: it parts the pipeline from the receiver.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (m_done) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (m_done) begin
      result.next_pc       <= m_op.next_pc;
      result.dest_written  <= m_op.reg_wr;
      result.dest_index    <= m_op.reg_wr ? m_op.widx : 5'd0;
      result.dest_value    <= m_op.reg_wr ? wb_lo : 64'd0;
      result.store_done    <= m_op.st_en;
      result.store_address <= m_op.st_en ? m_op.st_addr : 32'd0;
      result.unhandled     <= m_op.unh;
    end
  end

endmodule
